FILE: rtl/swpc_pkg.sv
// Shared types, constants and color table of the spot-weld pulse controller.
`timescale 1ns / 1ps
`default_nettype none

package swpc_pkg;

    // One input item: a millisecond tick with the button events and the temperature.
    typedef struct packed {
        logic               mode_click;
        logic               weld_press;
        logic signed [11:0] temperature;
    } t_in_item;

    // One result item: relay drives, inverted LED duties and the status code.
    typedef struct packed {
        logic       main_relay;
        logic       fan_relay;
        logic [7:0] led_red_drive;
        logic [7:0] led_green_drive;
        logic [7:0] led_blue_drive;
        logic [2:0] status_code;
    } t_out_item;

    // LED levels as shown, before inversion.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WELD_TIME0    = 3'd0;
    localparam logic [2:0] CFG_WELD_TIME1    = 3'd1;
    localparam logic [2:0] CFG_WELD_TIME2    = 3'd2;
    localparam logic [2:0] CFG_WELD_TIME3    = 3'd3;
    localparam logic [2:0] CFG_WELD_TIME4    = 3'd4;
    localparam logic [2:0] CFG_OVERHEAT_LIM  = 3'd5;
    localparam logic [2:0] CFG_FAN_THRESHOLD = 3'd6;
    localparam logic [2:0] CFG_FAN_OFF_DELAY = 3'd7;

    // Status codes.
    localparam logic [2:0] STATUS_MODE_FIRST = 3'd0;
    localparam logic [2:0] STATUS_MODE_LAST  = 3'd4;
    localparam logic [2:0] STATUS_LOCKOUT    = 3'd5;

    // Configuration reset values.
    localparam logic [15:0] RST_WELD_TIME0    = 16'd100;
    localparam logic [15:0] RST_WELD_TIME1    = 16'd250;
    localparam logic [15:0] RST_WELD_TIME2    = 16'd400;
    localparam logic [15:0] RST_WELD_TIME3    = 16'd600;
    localparam logic [15:0] RST_WELD_TIME4    = 16'd1200;
    localparam logic [10:0] RST_OVERHEAT_LIM  = 11'd400;
    localparam logic [10:0] RST_FAN_THRESHOLD = 11'd400;
    localparam logic [15:0] RST_FAN_OFF_DELAY = 16'd15000;

    // Timing constants in milliseconds.
    localparam logic [16:0] WELD_GAP_MS = 17'd1000;
    localparam logic [16:0] FAN_GAP_MS  = 17'd1000;
    localparam logic [14:0] LOCKOUT_MS  = 15'd30000;
    localparam logic [6:0]  SAMPLE_MS   = 7'd100;
    localparam logic [8:0]  BLINK_MS    = 9'd500;

    // Lockout release: temperature below 85 percent of the limit, in integer form.
    localparam logic signed [19:0] RELEASE_NUM = 20'sd85;
    localparam logic signed [19:0] RELEASE_DEN = 20'sd100;

    // Color shown for each status.
    function automatic t_rgb status_color(input logic [2:0] st);
        t_rgb c;
        case (st)
            3'd0:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
            3'd1:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
            3'd2:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
            3'd3:    c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
            default: c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/spot_weld_pulse_controller_core.sv
// Spot-weld pulse controller: mode, weld pulse, overheat lockout, fan and LED blink.
//
// Usage: each input item is one millisecond tick carrying a mode click, a weld
// press and the signed temperature in tenths of a degree. Every accepted item
// yields exactly one result item with the relay drives, the inverted LED duties
// and the status code (0 to 4 weld mode, 5 overheat lockout).
// Channels: input, output and configuration each use valid and ready. The
// configuration port is always ready and takes a 3-bit register index with
// 16 bits of data; the narrow registers keep the low bits. Write it only while
// no item is in flight.
// Path: an accepted item is held in the input register, and its result is
// loaded into the output register when the stage advances, which waits while
// the output register holds a result that the receiver has not taken.
// Throughput: one item per cycle while the output is not stalled; all controller
// state is computed combinationally between the input and output registers.
// Stalls: the output register holds its result while the receiver is not ready;
// the input register then holds the next item and the input side stalls only
// when both registers are full.
// Reset: synchronous, active low; clears both pipeline registers, returns all
// counters and relays to zero, mode 0 with the cyan LED, and loads the default
// weld times and thresholds.
`timescale 1ns / 1ps
`default_nettype none

module spot_weld_pulse_controller_core (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  swpc_pkg::t_in_item       i_in_item,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output swpc_pkg::t_out_item      o_out_item,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire  [2:0]               i_cfg_index,
    input  wire  [15:0]              i_cfg_data
);

    // Controller state carried from item to item.
    typedef struct packed {
        logic [2:0]     status;
        logic [2:0]     saved_status;
        logic           pulse_active;
        logic [16:0]    weld_elapsed;
        logic [14:0]    lockout_elapsed;
        logic [6:0]     sample_elapsed;
        logic [8:0]     blink_elapsed;
        logic           blink_running;
        logic           blink_phase_on;
        logic           blink_stop_req;
        logic           main_relay;
        logic           fan_relay;
        swpc_pkg::t_rgb led;
    } t_ctl_state;

    // Status change: show the new color and start the blink or request that it stop.
    function automatic t_ctl_state set_status(input t_ctl_state s, input logic [2:0] st);
        t_ctl_state r;
        r     = s;
        r.led = swpc_pkg::status_color(st);
        if (st == swpc_pkg::STATUS_LOCKOUT) begin
            r.blink_running  = 1'b1;
            r.blink_stop_req = 1'b0;
            r.blink_elapsed  = '0;
        end else begin
            r.blink_stop_req = 1'b1;
        end
        r.status = st;
        return r;
    endfunction

    logic [15:0]         r_weld_time [5];
    logic [10:0]         r_overheat_limit;
    logic [10:0]         r_fan_threshold;
    logic [15:0]         r_fan_off_delay;

    logic                r_in_valid;
    swpc_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    swpc_pkg::t_out_item r_out_item;
    t_ctl_state          r_st;
    t_ctl_state          n_st;
    swpc_pkg::t_out_item n_out_item;

    logic                advance;
    logic signed [12:0]  temp_ext;
    logic signed [12:0]  limit_ext;
    logic signed [12:0]  fan_thr_ext;
    logic signed [19:0]  temp_scaled;
    logic signed [19:0]  limit_scaled;
    logic [15:0]         mode_weld_time;

    // Handshakes: a held item advances if the output register is free or being emptied.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Temperature comparisons on sign-extended values.
    assign temp_ext     = {r_in_item.temperature[11], r_in_item.temperature};
    assign limit_ext    = $signed({2'b00, r_overheat_limit});
    assign fan_thr_ext  = $signed({2'b00, r_fan_threshold});
    assign temp_scaled  = $signed({{7{temp_ext[12]}}, temp_ext}) * swpc_pkg::RELEASE_DEN;
    assign limit_scaled = $signed({7'b0, limit_ext}) * swpc_pkg::RELEASE_NUM;

    // Next controller state and result for the item in the input register.
    always_comb begin
        n_st = r_st;

        // Elapsed counters advance first, saturating except the sample counter.
        if (n_st.weld_elapsed != '1) begin
            n_st.weld_elapsed = n_st.weld_elapsed + 17'd1;
        end
        if (n_st.lockout_elapsed != '1) begin
            n_st.lockout_elapsed = n_st.lockout_elapsed + 15'd1;
        end
        if (n_st.blink_elapsed != '1) begin
            n_st.blink_elapsed = n_st.blink_elapsed + 9'd1;
        end
        n_st.sample_elapsed = n_st.sample_elapsed + 7'd1;

        // Mode click steps through the weld modes outside lockout.
        if (r_in_item.mode_click && n_st.status != swpc_pkg::STATUS_LOCKOUT) begin
            if (n_st.status >= swpc_pkg::STATUS_MODE_LAST) begin
                n_st = set_status(n_st, swpc_pkg::STATUS_MODE_FIRST);
            end else begin
                n_st = set_status(n_st, n_st.status + 3'd1);
            end
        end

        // Weld press starts a pulse after the gap since the last timer restart.
        if (r_in_item.weld_press && n_st.status != swpc_pkg::STATUS_LOCKOUT &&
            !n_st.pulse_active && n_st.weld_elapsed > swpc_pkg::WELD_GAP_MS) begin
            n_st.fan_relay    = 1'b1;
            n_st.main_relay   = 1'b1;
            n_st.pulse_active = 1'b1;
            n_st.weld_elapsed = '0;
        end

        // Error blink toggles between the status color and off.
        if (n_st.blink_running && n_st.blink_elapsed > swpc_pkg::BLINK_MS) begin
            n_st.led = n_st.blink_phase_on ? swpc_pkg::status_color(n_st.status) : '0;
            if (n_st.blink_phase_on && n_st.blink_stop_req) begin
                n_st.blink_running = 1'b0;
            end
            n_st.blink_elapsed  = '0;
            n_st.blink_phase_on = !n_st.blink_phase_on;
        end

        // Periodic temperature check: lockout entry and exit, fan start and stop.
        if (n_st.sample_elapsed > swpc_pkg::SAMPLE_MS) begin
            if (n_st.status != swpc_pkg::STATUS_LOCKOUT && temp_ext > limit_ext) begin
                n_st.saved_status    = n_st.status;
                n_st                 = set_status(n_st, swpc_pkg::STATUS_LOCKOUT);
                n_st.fan_relay       = 1'b1;
                n_st.main_relay      = 1'b0;
                n_st.pulse_active    = 1'b0;
                n_st.lockout_elapsed = '0;
            end
            if (n_st.status == swpc_pkg::STATUS_LOCKOUT && temp_scaled < limit_scaled &&
                n_st.lockout_elapsed > swpc_pkg::LOCKOUT_MS) begin
                n_st.weld_elapsed    = '0;
                n_st                 = set_status(n_st, n_st.saved_status);
                n_st.lockout_elapsed = '0;
            end
            if (temp_ext > fan_thr_ext && n_st.weld_elapsed > swpc_pkg::FAN_GAP_MS) begin
                n_st.fan_relay    = 1'b1;
                n_st.weld_elapsed = '0;
            end
            if (n_st.weld_elapsed > {1'b0, r_fan_off_delay} && temp_ext < fan_thr_ext &&
                n_st.lockout_elapsed > swpc_pkg::LOCKOUT_MS) begin
                n_st.fan_relay    = 1'b0;
                n_st.weld_elapsed = '0;
            end
            n_st.sample_elapsed = '0;
        end

        // Pulse end once the weld time of the current mode has passed.
        mode_weld_time = r_weld_time[n_st.status];
        if (n_st.status <= swpc_pkg::STATUS_MODE_LAST && n_st.pulse_active &&
            n_st.weld_elapsed > {1'b0, mode_weld_time}) begin
            n_st.main_relay   = 1'b0;
            n_st.pulse_active = 1'b0;
            n_st.weld_elapsed = '0;
        end

        // Result item from the updated state.
        n_out_item.main_relay      = n_st.main_relay;
        n_out_item.fan_relay       = n_st.fan_relay;
        n_out_item.led_red_drive   = ~n_st.led.red;
        n_out_item.led_green_drive = ~n_st.led.green;
        n_out_item.led_blue_drive  = ~n_st.led.blue;
        n_out_item.status_code     = n_st.status;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weld_time[0]   <= swpc_pkg::RST_WELD_TIME0;
            r_weld_time[1]   <= swpc_pkg::RST_WELD_TIME1;
            r_weld_time[2]   <= swpc_pkg::RST_WELD_TIME2;
            r_weld_time[3]   <= swpc_pkg::RST_WELD_TIME3;
            r_weld_time[4]   <= swpc_pkg::RST_WELD_TIME4;
            r_overheat_limit <= swpc_pkg::RST_OVERHEAT_LIM;
            r_fan_threshold  <= swpc_pkg::RST_FAN_THRESHOLD;
            r_fan_off_delay  <= swpc_pkg::RST_FAN_OFF_DELAY;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index) inside
                swpc_pkg::CFG_WELD_TIME0, swpc_pkg::CFG_WELD_TIME1,
                swpc_pkg::CFG_WELD_TIME2, swpc_pkg::CFG_WELD_TIME3,
                swpc_pkg::CFG_WELD_TIME4: begin
                    r_weld_time[i_cfg_index] <= i_cfg_data;
                end
                swpc_pkg::CFG_OVERHEAT_LIM: begin
                    r_overheat_limit <= i_cfg_data[10:0];
                end
                swpc_pkg::CFG_FAN_THRESHOLD: begin
                    r_fan_threshold <= i_cfg_data[10:0];
                end
                swpc_pkg::CFG_FAN_OFF_DELAY: begin
                    r_fan_off_delay <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Input register, controller state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '{
                status:          swpc_pkg::STATUS_MODE_FIRST,
                saved_status:    swpc_pkg::STATUS_MODE_FIRST,
                pulse_active:    1'b0,
                weld_elapsed:    '0,
                lockout_elapsed: '0,
                sample_elapsed:  '0,
                blink_elapsed:   '0,
                blink_running:   1'b0,
                blink_phase_on:  1'b1,
                blink_stop_req:  1'b0,
                main_relay:      1'b0,
                fan_relay:       1'b0,
                led:             swpc_pkg::status_color(swpc_pkg::STATUS_MODE_FIRST)
            };
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_st        <= n_st;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/swpc_checker.sv
// Port-level checks of the spot-weld pulse controller and their binding.
`timescale 1ns / 1ps
`default_nettype none

module swpc_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input swpc_pkg::t_out_item o_out_item
);

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Status codes above the lockout code never appear.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status_code <= swpc_pkg::STATUS_LOCKOUT)
        else $error("status code out of range");

    // The weld relay is open during lockout.
    a_lockout_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status_code == swpc_pkg::STATUS_LOCKOUT
        |-> !o_out_item.main_relay)
        else $error("weld relay closed in lockout");

    // During lockout the LED shows only red or is dark.
    a_lockout_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status_code == swpc_pkg::STATUS_LOCKOUT
        |-> o_out_item.led_green_drive == 8'hFF && o_out_item.led_blue_drive == 8'hFF)
        else $error("lockout LED color not red");

endmodule

bind spot_weld_pulse_controller_core swpc_checker u_swpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire
